FILE: sv/crsc_pkg.sv
// Shared types, angle constants and arctangent table for the CORDIC sine/cosine unit.
package crsc_pkg;

  // Angle constants in Q3.12, held at 17 bits for range reduction
  localparam logic signed [16:0] PI_Q      = 17'sd12868;
  localparam logic signed [16:0] HALF_PI_Q = 17'sd6434;
  localparam logic signed [16:0] TWO_PI_Q  = 17'sd25736;

  // Configuration register indexes
  localparam logic CFG_LAST_ITER = 1'b0;
  localparam logic CFG_GAIN      = 1'b1;

  localparam logic [3:0]  LAST_ITER_RESET = 4'd12;
  localparam logic [11:0] GAIN_RESET      = 12'd2487;

  // Control that travels down the pipeline with each beat
  typedef struct packed {
    logic valid;
    logic negate;
  } crsc_ctrl_t;

  // round(atan(2^-i) * 4096)
  function automatic logic [11:0] atan_q12(input logic [3:0] idx);
    logic [11:0] v;
    case (idx)
      4'd0:    v = 12'd3217;
      4'd1:    v = 12'd1899;
      4'd2:    v = 12'd1003;
      4'd3:    v = 12'd509;
      4'd4:    v = 12'd256;
      4'd5:    v = 12'd128;
      4'd6:    v = 12'd64;
      4'd7:    v = 12'd32;
      4'd8:    v = 12'd16;
      4'd9:    v = 12'd8;
      4'd10:   v = 12'd4;
      4'd11:   v = 12'd2;
      4'd12:   v = 12'd1;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/cordic_rotation_sin_cos_unit.sv
// Pipelined CORDIC rotation-mode sine/cosine generator, top level.
// Registers in order: range reduction, quadrant fold, one register per
//   micro-rotation, output negate register.
// Throughput: one angle per cycle; the pipeline is a single shift chain, so a stall on
//   the result side freezes every stage together.
// Reset clears all valid bits and loads last_iteration = 12, gain_start = 2487.
module cordic_rotation_sin_cos_unit import crsc_pkg::*; #(
  parameter int TABLE_ENTRIES = 13,
  parameter int DATA_WIDTH    = 16,
  parameter int MAX_STAGES    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sine_o,
  output logic signed [15:0] cosine_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [11:0]        cfg_data_i
);

  localparam int DW = DATA_WIDTH;

  logic [3:0]  last_iter_q;
  logic [11:0] gain_q;
  logic        adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_iter_q <= LAST_ITER_RESET;
      gain_q      <= GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LAST_ITER: last_iter_q <= cfg_data_i[3:0];
        CFG_GAIN:      gain_q      <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Whole pipeline moves unless the result register holds an untaken beat
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Range reduction into [-pi, pi)
  logic               red_vld_q;
  logic signed [15:0] red_a_q;
  logic signed [16:0] a_ext, red_d;

  assign a_ext = 17'(angle_i);

  always_comb begin
    red_d = a_ext;
    if (a_ext < -PI_Q) begin
      red_d = a_ext + TWO_PI_Q;
    end else if (a_ext >= PI_Q) begin
      red_d = a_ext - TWO_PI_Q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_vld_q <= 1'b0;
    end else if (adv) begin
      red_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_a_q <= red_d[15:0];
    end
  end

  // Quadrant fold into [-pi/2, pi/2], noting the needed negation
  crsc_ctrl_t         fold_ctrl_d;
  logic signed [16:0] red_ext, fold_d;

  assign red_ext = 17'(red_a_q);

  always_comb begin
    fold_d             = red_ext;
    fold_ctrl_d.valid  = red_vld_q;
    fold_ctrl_d.negate = 1'b0;
    if (red_ext < -HALF_PI_Q) begin
      fold_d             = red_ext + PI_Q;
      fold_ctrl_d.negate = 1'b1;
    end else if (red_ext > HALF_PI_Q) begin
      fold_d             = red_ext - PI_Q;
      fold_ctrl_d.negate = 1'b1;
    end
  end

  crsc_ctrl_t                   ctrl_s [0:MAX_STAGES];
  logic signed [DW-1:0]         x_s    [0:MAX_STAGES];
  logic signed [DW-1:0]         y_s    [0:MAX_STAGES];
  logic signed [DW-1:0]         z_s    [0:MAX_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_s[0] <= '0;
    end else if (adv) begin
      ctrl_s[0] <= fold_ctrl_d;
    end
  end

  // Seed vector: x = gain, y = 0, z = folded angle (cast to DW bits)
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_s[0] <= $signed({{(DW-12){1'b0}}, gain_q});
      y_s[0] <= '0;
      z_s[0] <= DW'(fold_d);
    end
  end

  // Micro-rotation chain; stages past last_iteration pass through
  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_stage
    crsc_stage #(
      .STAGE         (i),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .DATA_WIDTH    (DW)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (adv),
      .active_i (last_iter_q >= 4'(i)),
      .ctrl_i   (ctrl_s[i]),
      .x_i      (x_s[i]),
      .y_i      (y_s[i]),
      .z_i      (z_s[i]),
      .ctrl_o   (ctrl_s[i+1]),
      .x_o      (x_s[i+1]),
      .y_o      (y_s[i+1]),
      .z_o      (z_s[i+1])
    );
  end

  // Output register with final negation
  logic                 out_vld_q;
  logic signed [15:0]   sine_q, cosine_q;
  logic signed [DW-1:0] x_fin, y_fin;

  assign x_fin = ctrl_s[MAX_STAGES].negate ? -x_s[MAX_STAGES] : x_s[MAX_STAGES];
  assign y_fin = ctrl_s[MAX_STAGES].negate ? -y_s[MAX_STAGES] : y_s[MAX_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= ctrl_s[MAX_STAGES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sine_q   <= y_fin[15:0];
      cosine_q <= x_fin[15:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign sine_o      = sine_q;
  assign cosine_o    = cosine_q;

  // Reduced angle always lands in [-pi, pi)
  a_red_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_vld_q |-> (17'(red_a_q) >= -PI_Q) && (17'(red_a_q) < PI_Q))
    else $error("reduced angle out of range");

  // Folded residual seeds within [-pi/2, pi/2]
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_s[0].valid |-> (z_s[0] >= -DW'(HALF_PI_Q)) && (z_s[0] <= DW'(HALF_PI_Q)))
    else $error("folded angle out of range");

  // A held result freezes the front of the pipeline too
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(ctrl_s[0]) && $stable(red_vld_q))
    else $error("pipeline moved during stall");

endmodule

FILE: sv/crsc_stage.sv
// One registered CORDIC micro-rotation stage with a fixed shift.
module crsc_stage import crsc_pkg::*; #(
  parameter int STAGE         = 0,
  parameter int TABLE_ENTRIES = 13,
  parameter int DATA_WIDTH    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         active_i,
  input  crsc_ctrl_t                   ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] x_i,
  input  logic signed [DATA_WIDTH-1:0] y_i,
  input  logic signed [DATA_WIDTH-1:0] z_i,
  output crsc_ctrl_t                   ctrl_o,
  output logic signed [DATA_WIDTH-1:0] x_o,
  output logic signed [DATA_WIDTH-1:0] y_o,
  output logic signed [DATA_WIDTH-1:0] z_o
);

  // Stages past the end of the table reuse its last entry
  localparam int TblIdx = (STAGE < TABLE_ENTRIES) ? STAGE : TABLE_ENTRIES - 1;
  localparam logic [11:0] AtanVal = atan_q12(4'(TblIdx));
  localparam logic signed [DATA_WIDTH-1:0] AtanDw =
    $signed({{(DATA_WIDTH-12){1'b0}}, AtanVal});

  crsc_ctrl_t                   ctrl_q;
  logic signed [DATA_WIDTH-1:0] x_d, y_d, z_d, x_q, y_q, z_q;
  logic signed [DATA_WIDTH-1:0] x_sh, y_sh;

  assign x_sh = x_i >>> STAGE;
  assign y_sh = y_i >>> STAGE;

  // Rotate toward zero residual; a zero residual takes the negative branch
  always_comb begin
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    if (active_i) begin
      if (z_i > 0) begin
        x_d = x_i - y_sh;
        y_d = y_i + x_sh;
        z_d = z_i - AtanDw;
      end else begin
        x_d = x_i + y_sh;
        y_d = y_i - x_sh;
        z_d = z_i + AtanDw;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule
